// ----- rtl/core/binary_load_stream_parser_assert.svh -----
// Assertion macros for the binary load stream parser
`ifndef BINARY_LOAD_STREAM_PARSER_ASSERT_SVH
`define BINARY_LOAD_STREAM_PARSER_ASSERT_SVH

`ifndef SYNTHESIS
`define BLSP_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("blsp assertion failed");
`define BLSP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("blsp assertion failed");
`else
`define BLSP_ASSERT_IMP(lbl, ante, cons)
`define BLSP_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ----- rtl/core/blsp_pkg.sv -----
package blsp_pkg;

  localparam logic [7:0]  HDR_BYTE   = 8'hff;
  localparam logic [15:0] REPEAT_HDR = 16'hffff;
  localparam logic [15:0] RUN_LO_ADR = 16'h02e0;
  localparam logic [15:0] RUN_HI_ADR = 16'h02e1;

  typedef enum logic [1:0] {
    EV_NONE      = 2'd0,
    EV_BAD_HDR   = 2'd1,
    EV_END_BELOW = 2'd2,
    EV_SEG_DONE  = 2'd3
  } ev_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       first_byte;
  } item_t;

  typedef struct packed {
    logic        write_valid;
    logic [15:0] write_address;
    logic [7:0]  write_data;
    ev_t         event_code;
    logic        run_vector_set;
    logic [15:0] run_vector;
  } res_t;

endpackage

// ----- rtl/core/blsp_in_reg.sv -----
module blsp_in_reg (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [7:0]           in_data_byte,
  input  logic                 in_first_byte,
  input  logic                 advance,
  output logic                 item_valid,
  output blsp_pkg::item_t      item
);
  import blsp_pkg::*;

  logic  valid_r;
  item_t item_r;

  assign in_ready   = !valid_r || advance;
  assign item_valid = valid_r;
  assign item       = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      valid_r <= 1'b1;
    end else if (advance) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r.data_byte  <= in_data_byte;
      item_r.first_byte <= in_first_byte;
    end
  end

endmodule

// ----- rtl/core/blsp_step.sv -----
`include "binary_load_stream_parser_assert.svh"

module blsp_step (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             advance,
  input  blsp_pkg::item_t  item,
  output blsp_pkg::res_t   res
);
  import blsp_pkg::*;

  typedef enum logic [2:0] {
    PH_HDR1 = 3'd0,
    PH_HDR2 = 3'd1,
    PH_SLO  = 3'd2,
    PH_SHI  = 3'd3,
    PH_ELO  = 3'd4,
    PH_EHI  = 3'd5,
    PH_DATA = 3'd6
  } phase_t;

  phase_t      phase_r, phase_nxt, phase_eff;
  logic [15:0] seg_addr_r, seg_addr_nxt;
  logic [15:0] seg_end_r, seg_end_nxt;
  logic [15:0] run_vec_r, run_vec_nxt, run_eff;
  logic [15:0] start_full;
  logic [15:0] end_full;

  assign start_full = {item.data_byte, seg_addr_r[7:0]};
  assign end_full   = {item.data_byte, seg_end_r[7:0]};

  always_comb begin
    phase_eff    = item.first_byte ? PH_HDR1 : phase_r;
    run_eff      = item.first_byte ? 16'h0000 : run_vec_r;
    phase_nxt    = phase_eff;
    seg_addr_nxt = seg_addr_r;
    seg_end_nxt  = seg_end_r;
    run_vec_nxt  = run_eff;
    res          = '0;
    res.event_code = EV_NONE;
    unique case (phase_eff)
      PH_HDR2: begin
        if (item.data_byte != HDR_BYTE) begin
          res.event_code = EV_BAD_HDR;
          phase_nxt      = PH_HDR1;
          run_vec_nxt    = 16'h0000;
        end else begin
          phase_nxt = PH_SLO;
        end
      end
      PH_SLO: begin
        seg_addr_nxt = {8'h00, item.data_byte};
        phase_nxt    = PH_SHI;
      end
      PH_SHI: begin
        seg_addr_nxt = start_full;
        if (start_full == REPEAT_HDR) begin
          phase_nxt = PH_SLO;
        end else begin
          if (run_eff == 16'h0000) begin
            run_vec_nxt        = start_full;
            res.run_vector_set = 1'b1;
          end
          phase_nxt = PH_ELO;
        end
      end
      PH_ELO: begin
        seg_end_nxt = {8'h00, item.data_byte};
        phase_nxt   = PH_EHI;
      end
      PH_EHI: begin
        seg_end_nxt = end_full;
        if (end_full < seg_addr_r) begin
          res.event_code = EV_END_BELOW;
          phase_nxt      = PH_HDR1;
          run_vec_nxt    = 16'h0000;
        end else begin
          phase_nxt = PH_DATA;
        end
      end
      PH_DATA: begin
        res.write_valid   = 1'b1;
        res.write_address = seg_addr_r;
        res.write_data    = item.data_byte;
        if (seg_addr_r == RUN_LO_ADR) begin
          run_vec_nxt = {run_eff[15:8], item.data_byte};
        end else if (seg_addr_r == RUN_HI_ADR) begin
          run_vec_nxt = {item.data_byte, run_eff[7:0]};
        end
        if (seg_addr_r == seg_end_r) begin
          res.event_code = EV_SEG_DONE;
          phase_nxt      = PH_SLO;
        end else begin
          seg_addr_nxt = seg_addr_r + 16'd1;
        end
      end
      default: begin
        if (item.data_byte != HDR_BYTE) begin
          res.event_code = EV_BAD_HDR;
          phase_nxt      = PH_HDR1;
          run_vec_nxt    = 16'h0000;
        end else begin
          phase_nxt = PH_HDR2;
        end
      end
    endcase
    res.run_vector = run_vec_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_HDR1;
      seg_addr_r <= 16'h0000;
      seg_end_r  <= 16'h0000;
      run_vec_r  <= 16'h0000;
    end else if (advance) begin
      phase_r    <= phase_nxt;
      seg_addr_r <= seg_addr_nxt;
      seg_end_r  <= seg_end_nxt;
      run_vec_r  <= run_vec_nxt;
    end
  end

  `BLSP_ASSERT_NEXT(a_err_restarts,
    advance && (res.event_code == EV_BAD_HDR || res.event_code == EV_END_BELOW),
    phase_r == PH_HDR1 && run_vec_r == 16'h0000)
  `BLSP_ASSERT_IMP(a_write_in_data,
    advance && res.write_valid, phase_r == PH_DATA && !item.first_byte)
  `BLSP_ASSERT_IMP(a_rset_from_zero,
    advance && res.run_vector_set, item.first_byte || run_vec_r == 16'h0000)

endmodule

// ----- rtl/core/blsp_out_reg.sv -----
module blsp_out_reg (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            item_valid,
  input  blsp_pkg::res_t  res,
  output logic            advance,
  output logic            out_valid,
  input  logic            out_ready,
  output logic            out_write_valid,
  output logic [15:0]     out_write_address,
  output logic [7:0]      out_write_data,
  output logic [1:0]      out_event_code,
  output logic            out_run_vector_set,
  output logic [15:0]     out_run_vector
);
  import blsp_pkg::*;

  logic valid_r;
  res_t res_r;

  assign advance = item_valid && (!valid_r || out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (advance) begin
      valid_r <= 1'b1;
    end else if (out_ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= res;
    end
  end

  assign out_valid          = valid_r;
  assign out_write_valid    = res_r.write_valid;
  assign out_write_address  = res_r.write_address;
  assign out_write_data     = res_r.write_data;
  assign out_event_code     = res_r.event_code;
  assign out_run_vector_set = res_r.run_vector_set;
  assign out_run_vector     = res_r.run_vector;

endmodule

// ----- rtl/core/binary_load_stream_parser.sv -----
// Binary load stream parser: takes one file byte per beat and returns one result beat per
// input beat, in order. A byte is held in an input register, parsed combinationally against
// the phase, segment address, segment end and run vector registers, and the result lands in
// an output register. Throughput is one byte per cycle while the output side does not stall;
// that rate is set by the combinational parse loop through the phase and address registers.
// While the downstream side stalls the block absorbs up to two beats, one in each register;
// in_ready drops only once both are full and then follows out_ready in the same cycle.
module binary_load_stream_parser (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_first_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_write_valid,
  output logic [15:0] out_write_address,
  output logic [7:0]  out_write_data,
  output logic [1:0]  out_event_code,
  output logic        out_run_vector_set,
  output logic [15:0] out_run_vector
);
  import blsp_pkg::*;

  logic  advance;
  logic  item_valid;
  item_t item;
  res_t  res;

  blsp_in_reg u_in_reg (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_data_byte  (in_data_byte),
    .in_first_byte (in_first_byte),
    .advance       (advance),
    .item_valid    (item_valid),
    .item          (item)
  );

  blsp_step u_step (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (advance),
    .item    (item),
    .res     (res)
  );

  blsp_out_reg u_out_reg (
    .clk                (clk),
    .rst_n              (rst_n),
    .item_valid         (item_valid),
    .res                (res),
    .advance            (advance),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_write_valid    (out_write_valid),
    .out_write_address  (out_write_address),
    .out_write_data     (out_write_data),
    .out_event_code     (out_event_code),
    .out_run_vector_set (out_run_vector_set),
    .out_run_vector     (out_run_vector)
  );

endmodule

// ----- tb/load_file_check_pkg.sv -----
package load_file_check_pkg;
  import blsp_pkg::*;

  typedef enum logic [2:0] {
    HDR_FIRST  = 3'd0,
    HDR_SECOND = 3'd1,
    START_LO   = 3'd2,
    START_HI   = 3'd3,
    END_LO     = 3'd4,
    END_HI     = 3'd5,
    DATA_BYTES = 3'd6
  } parse_phase_t;

  class load_file_scoreboard;
    parse_phase_t phase;
    logic [15:0]  seg_adr;
    logic [15:0]  seg_end;
    logic [15:0]  run_vec;
    res_t         expected_q[$];
    int unsigned  errors;

    function new();
      phase   = HDR_FIRST;
      seg_adr = '0;
      seg_end = '0;
      run_vec = '0;
      errors  = 0;
    endfunction

    function void restart_parse();
      phase   = HDR_FIRST;
      run_vec = '0;
    endfunction

    function res_t parse_byte(logic [7:0] b, logic first);
      res_t r;
      r = '0;
      r.event_code = EV_NONE;
      if (first) begin
        restart_parse();
      end
      case (phase)
        HDR_SECOND: begin
          if (b != HDR_BYTE) begin
            r.event_code = EV_BAD_HDR;
            restart_parse();
          end else begin
            phase = START_LO;
          end
        end
        START_LO: begin
          seg_adr = {8'h00, b};
          phase   = START_HI;
        end
        START_HI: begin
          seg_adr = {b, seg_adr[7:0]};
          if (seg_adr == REPEAT_HDR) begin
            phase = START_LO;
          end else begin
            if (run_vec == 16'h0000) begin
              run_vec          = seg_adr;
              r.run_vector_set = 1'b1;
            end
            phase = END_LO;
          end
        end
        END_LO: begin
          seg_end = {8'h00, b};
          phase   = END_HI;
        end
        END_HI: begin
          seg_end = {b, seg_end[7:0]};
          if (seg_end < seg_adr) begin
            r.event_code = EV_END_BELOW;
            restart_parse();
          end else begin
            phase = DATA_BYTES;
          end
        end
        DATA_BYTES: begin
          r.write_valid   = 1'b1;
          r.write_address = seg_adr;
          r.write_data    = b;
          if (seg_adr == RUN_LO_ADR) begin
            run_vec[7:0] = b;
          end else if (seg_adr == RUN_HI_ADR) begin
            run_vec[15:8] = b;
          end
          if (seg_adr == seg_end) begin
            r.event_code = EV_SEG_DONE;
            phase        = START_LO;
          end else begin
            seg_adr = seg_adr + 16'd1;
          end
        end
        default: begin
          if (b != HDR_BYTE) begin
            r.event_code = EV_BAD_HDR;
            restart_parse();
          end else begin
            phase = HDR_SECOND;
          end
        end
      endcase
      r.run_vector = run_vec;
      return r;
    endfunction

    function void note_byte(logic [7:0] b, logic first);
      expected_q.push_back(parse_byte(b, first));
    endfunction

    function void mismatch(string field, logic [15:0] want, logic [15:0] got);
      $error("%s: expected %0h, got %0h", field, want, got);
      errors++;
    endfunction

    function void check_result(res_t got);
      res_t want;
      if (expected_q.size() == 0) begin
        $error("result beat with no byte pending");
        errors++;
        return;
      end
      want = expected_q.pop_front();
      if (got.write_valid !== want.write_valid)
        mismatch("write_valid", want.write_valid, got.write_valid);
      if (got.write_address !== want.write_address)
        mismatch("write_address", want.write_address, got.write_address);
      if (got.write_data !== want.write_data)
        mismatch("write_data", want.write_data, got.write_data);
      if (got.event_code !== want.event_code)
        mismatch("event_code", want.event_code, got.event_code);
      if (got.run_vector_set !== want.run_vector_set)
        mismatch("run_vector_set", want.run_vector_set, got.run_vector_set);
      if (got.run_vector !== want.run_vector)
        mismatch("run_vector", want.run_vector, got.run_vector);
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction
  endclass

endpackage

// ----- tb/tb_top.sv -----
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import blsp_pkg::*;
  import load_file_check_pkg::*;

  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned FILE_BYTES  = 900;

  logic        clk;
  logic        rst_n         = 1'b0;
  logic        in_valid      = 1'b0;
  logic        in_ready;
  logic [7:0]  in_data_byte  = 8'h00;
  logic        in_first_byte = 1'b0;
  logic        out_valid;
  logic        out_ready     = 1'b0;
  logic        out_write_valid;
  logic [15:0] out_write_address;
  logic [7:0]  out_write_data;
  logic [1:0]  out_event_code;
  logic        out_run_vector_set;
  logic [15:0] out_run_vector;

  load_file_scoreboard sb = new();

  logic [7:0]  byte_q[$];
  bit          mark_q[$];
  int unsigned idle_cycles = 0;

  binary_load_stream_parser u_top (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_data_byte       (in_data_byte),
    .in_first_byte      (in_first_byte),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_write_valid    (out_write_valid),
    .out_write_address  (out_write_address),
    .out_write_data     (out_write_data),
    .out_event_code     (out_event_code),
    .out_run_vector_set (out_run_vector_set),
    .out_run_vector     (out_run_vector)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(5, 30);
  endfunction

  function void push_byte(logic [7:0] b, bit first);
    byte_q.push_back(b);
    mark_q.push_back(first);
  endfunction

  function void push_le_word(logic [15:0] w);
    push_byte(w[7:0], 1'b0);
    push_byte(w[15:8], 1'b0);
  endfunction

  function void gen_load_file();
    int unsigned nseg;
    int unsigned len;
    int unsigned n;
    logic [15:0] start_adr;
    logic [15:0] end_adr;
    push_byte(HDR_BYTE, $urandom_range(0, 3) != 0);
    push_byte(HDR_BYTE, 1'b0);
    nseg = $urandom_range(1, 4);
    for (int s = 0; s < nseg; s++) begin
      if ($urandom_range(0, 5) == 0) push_le_word(REPEAT_HDR);
      case ($urandom_range(0, 9))
        0:       start_adr = 16'h0000;
        1, 2:    start_adr = RUN_LO_ADR - 16'($urandom_range(0, 3));
        3:       start_adr = 16'hfffe - 16'($urandom_range(0, 12));
        default: start_adr = 16'($urandom);
      endcase
      if (start_adr == REPEAT_HDR) start_adr = 16'hfffe;
      if (start_adr != 16'h0000 && $urandom_range(0, 11) == 0) begin
        push_le_word(start_adr);
        push_le_word(16'($urandom_range(0, start_adr - 1)));
        return;
      end
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
      if (32'(start_adr) + len - 1 > 32'hffff) end_adr = 16'hffff;
      else end_adr = start_adr + 16'(len - 1);
      push_le_word(start_adr);
      push_le_word(end_adr);
      n = 32'(end_adr) - 32'(start_adr) + 1;
      repeat (n) push_byte(8'($urandom), 1'b0);
    end
  endfunction

  task automatic send_byte(input logic [7:0] b, input bit first, input int unsigned gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_data_byte  <= b;
    in_first_byte <= first;
    do @(posedge clk); while (!in_ready);
    sb.note_byte(b, first);
  endtask

  initial begin
    bit in_calm;
    in_calm = 1'b0;

    push_byte(HDR_BYTE, 1'b1);
    push_byte(HDR_BYTE, 1'b0);
    push_le_word(REPEAT_HDR);
    push_le_word(RUN_LO_ADR);
    push_le_word(RUN_HI_ADR);
    push_byte(8'h34, 1'b0);
    push_byte(8'h12, 1'b0);
    push_le_word(16'hfffe);
    push_le_word(16'hffff);
    push_byte(8'haa, 1'b0);
    push_byte(8'h55, 1'b0);
    push_le_word(16'h0000);
    push_le_word(16'h0005);
    push_byte(8'h01, 1'b0);
    push_byte(8'h7f, 1'b1);
    push_byte(HDR_BYTE, 1'b0);
    push_byte(8'h7f, 1'b0);
    push_byte(HDR_BYTE, 1'b0);
    push_byte(HDR_BYTE, 1'b0);
    push_le_word(16'h0010);
    push_le_word(16'h0000);

    while (byte_q.size() < FILE_BYTES) begin
      case ($urandom_range(0, 9))
        8: repeat ($urandom_range(1, 6)) push_byte(8'($urandom), $urandom_range(0, 3) == 0);
        9: begin
          gen_load_file();
          repeat ($urandom_range(1, 4)) begin
            void'(byte_q.pop_back());
            void'(mark_q.pop_back());
          end
        end
        default: gen_load_file();
      endcase
    end

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < byte_q.size(); i++) begin
      if (i % 64 == 0) in_calm = ($urandom_range(0, 5) == 0);
      send_byte(byte_q[i], mark_q[i], in_calm ? 0 : pick_gap());
    end
    in_valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    int unsigned stall_left;
    int unsigned cyc;
    bit          out_calm;
    stall_left = 0;
    cyc        = 0;
    out_calm   = 1'b0;
    forever begin
      @(posedge clk);
      cyc++;
      if (cyc % 256 == 0) out_calm = ($urandom_range(0, 4) == 0);
      if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        out_ready <= 1'b1;
        if (!out_calm && $urandom_range(0, 3) == 0) stall_left = pick_gap();
      end
    end
  end

  always @(posedge clk) begin
    res_t got;
    if (rst_n && out_valid && out_ready) begin
      got.write_valid    = out_write_valid;
      got.write_address  = out_write_address;
      got.write_data     = out_write_data;
      got.event_code     = ev_t'(out_event_code);
      got.run_vector_set = out_run_vector_set;
      got.run_vector     = out_run_vector;
      sb.check_result(got);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles + 1 >= STALL_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

endmodule
